// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/smbr_pkg.sv -----
package smbr_pkg;

    localparam int MAX_BLOCK_BYTES  = 240;
    localparam int MAX_PACKET_BYTES = 2048;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 12;
    localparam int CFG_W   = 12;
    localparam int INDEX_W = 3;

    typedef enum logic [INDEX_W-1:0] {
        REG_BUFFER_LIMIT   = 3'd0,
        REG_FIRST_OPCODE   = 3'd1,
        REG_MIDDLE_OPCODE  = 3'd2,
        REG_LAST_OPCODE    = 3'd3,
        REG_STATUS_OPCODE  = 3'd4,
        REG_LAST_BLOCK_LEN = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        RC_NONE      = 4'd0,
        RC_DONE      = 4'd1,
        RC_NOPKT     = 4'd2,
        RC_DUPFIRST  = 4'd3,
        RC_MIDEARLY  = 4'd4,
        RC_LASTEARLY = 4'd5,
        RC_BADLAST   = 4'd6,
        RC_STATMID   = 4'd7,
        RC_BADOP     = 4'd8,
        RC_BADSIZE   = 4'd9,
        RC_BUSERR    = 4'd10
    } result_code_t;

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_COPY = 2'd1
    } block_kind_t;

    typedef struct packed {
        logic [LEN_W-1:0]  buffer_limit;
        logic [BYTE_W-1:0] first_opcode;
        logic [BYTE_W-1:0] middle_opcode;
        logic [BYTE_W-1:0] last_opcode;
        logic [BYTE_W-1:0] status_opcode;
        logic [BYTE_W-1:0] last_block_len;
    } cfg_t;

    typedef struct packed {
        logic              awaiting_first;
        logic              opcode_next;
        logic [BYTE_W-1:0] block_remaining;
        block_kind_t       block_kind;
        logic [LEN_W-1:0]  copied_count;
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_count;
        logic              xfer_error;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        result_code_t      result_code;
        logic [LEN_W-1:0]  packet_len;
    } result_t;

endpackage

// ----- rtl/smbus_packet_reassembler_top.sv -----
// SMBus block-read reassembler: one received byte per request, one result per
// byte. A request is taken every cycle while the result register is empty or
// its result is being taken in the same cycle, so the sustained rate is one
// byte per clock; each result is loaded into the result register in the cycle
// after its byte is accepted, set by the single decode step between the state
// registers and that register. Configuration writes are registered and
// should be made only while no request is in flight.
`include "assert_macros.svh"

module smbus_packet_reassembler_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [smbr_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [smbr_pkg::CFG_W-1:0]          cfg_wdata,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [smbr_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                                is_count,
    input  logic                                xfer_error,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [smbr_pkg::BYTE_W-1:0]         payload_byte,
    output logic                                payload_valid,
    output logic [3:0]                          result_code,
    output logic [smbr_pkg::LEN_W-1:0]          packet_len
);

    smbr_pkg::cfg_t    cfg_reg;
    smbr_pkg::state_t  state_reg;
    smbr_pkg::state_t  state_next;
    smbr_pkg::item_t   item;
    smbr_pkg::result_t res;
    smbr_pkg::result_t res_out;
    logic              accept;

    assign item.rx_byte    = rx_byte;
    assign item.is_count   = is_count;
    assign item.xfer_error = xfer_error;
    assign accept          = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_limit   <= smbr_pkg::LEN_W'(2048);
            cfg_reg.first_opcode   <= 8'd144;
            cfg_reg.middle_opcode  <= 8'd16;
            cfg_reg.last_opcode    <= 8'd80;
            cfg_reg.status_opcode  <= 8'd221;
            cfg_reg.last_block_len <= 8'd17;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smbr_pkg::REG_BUFFER_LIMIT:   cfg_reg.buffer_limit   <= cfg_wdata;
                smbr_pkg::REG_FIRST_OPCODE:   cfg_reg.first_opcode   <= cfg_wdata[7:0];
                smbr_pkg::REG_MIDDLE_OPCODE:  cfg_reg.middle_opcode  <= cfg_wdata[7:0];
                smbr_pkg::REG_LAST_OPCODE:    cfg_reg.last_opcode    <= cfg_wdata[7:0];
                smbr_pkg::REG_STATUS_OPCODE:  cfg_reg.status_opcode  <= cfg_wdata[7:0];
                smbr_pkg::REG_LAST_BLOCK_LEN: cfg_reg.last_block_len <= cfg_wdata[7:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.awaiting_first  <= 1'b1;
            state_reg.opcode_next     <= 1'b0;
            state_reg.block_remaining <= '0;
            state_reg.block_kind      <= smbr_pkg::KIND_SKIP;
            state_reg.copied_count    <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    smbr_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (res)
    );

    smbr_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign payload_byte  = res_out.payload_byte;
    assign payload_valid = res_out.payload_valid;
    assign result_code   = res_out.result_code;
    assign packet_len    = res_out.packet_len;

    `ASSERT_SAME(a_idle_count_clear, clk, rst_n, state_reg.awaiting_first, state_reg.copied_count == '0, "copied bytes held with no packet open")
    `ASSERT_SAME(a_copy_has_len, clk, rst_n, out_valid && payload_valid, (packet_len != '0) && (result_code == smbr_pkg::RC_NONE), "copied byte with bad length or code")
    `ASSERT_NEXT(a_bus_error_code, clk, rst_n, accept && xfer_error, out_valid && (result_code == smbr_pkg::RC_BUSERR), "bus error not reported")

endmodule

// ----- rtl/smbr_step.sv -----
module smbr_step
(
    input  smbr_pkg::cfg_t    cfg,
    input  smbr_pkg::state_t  state,
    input  smbr_pkg::item_t   item,
    output smbr_pkg::state_t  state_next,
    output smbr_pkg::result_t result
);

    localparam int LIMIT_W = 17;

    logic [LIMIT_W-1:0]          limit_wide;
    logic [smbr_pkg::LEN_W-1:0]  limit;
    smbr_pkg::result_code_t      code;
    logic [smbr_pkg::BYTE_W-1:0] b;
    logic                        bad_size;

    // Effective limit is the smaller of the register and the packet maximum.
    assign limit_wide = (LIMIT_W'(cfg.buffer_limit) < LIMIT_W'(smbr_pkg::MAX_PACKET_BYTES))
                      ? LIMIT_W'(cfg.buffer_limit)
                      : LIMIT_W'(smbr_pkg::MAX_PACKET_BYTES);
    assign limit    = limit_wide[smbr_pkg::LEN_W-1:0];
    assign b        = item.rx_byte;
    assign bad_size = (b == '0) || (b > smbr_pkg::BYTE_W'(smbr_pkg::MAX_BLOCK_BYTES));

    always_comb
    begin
        state_next           = state;
        code                 = smbr_pkg::RC_NONE;
        result.payload_byte  = '0;
        result.payload_valid = 1'b0;
        result.packet_len    = state.copied_count;

        if (item.xfer_error)
        begin
            code                       = smbr_pkg::RC_BUSERR;
            state_next.opcode_next     = 1'b0;
            state_next.block_remaining = '0;
            state_next.block_kind      = smbr_pkg::KIND_SKIP;
        end
        else if (item.is_count)
        begin
            state_next.block_kind = smbr_pkg::KIND_SKIP;
            if (bad_size)
            begin
                code                       = smbr_pkg::RC_BADSIZE;
                state_next.opcode_next     = 1'b0;
                state_next.block_remaining = '0;
            end
            else
            begin
                state_next.opcode_next     = 1'b1;
                state_next.block_remaining = b;
            end
        end
        else if (state.opcode_next)
        begin
            state_next.opcode_next     = 1'b0;
            state_next.block_remaining = state.block_remaining - 1'b1;
            state_next.block_kind      = smbr_pkg::KIND_SKIP;
            // Opcodes are tried in priority order when registers collide.
            if (b == cfg.first_opcode)
            begin
                if (!state.awaiting_first)
                begin
                    code = smbr_pkg::RC_DUPFIRST;
                end
                else
                begin
                    state_next.awaiting_first = 1'b0;
                    state_next.block_kind     = smbr_pkg::KIND_COPY;
                end
            end
            else if (b == cfg.middle_opcode)
            begin
                if (state.awaiting_first)
                begin
                    code = smbr_pkg::RC_MIDEARLY;
                end
                else
                begin
                    state_next.block_kind = smbr_pkg::KIND_COPY;
                end
            end
            else if (b == cfg.last_opcode)
            begin
                if (state.awaiting_first)
                begin
                    code = smbr_pkg::RC_LASTEARLY;
                end
                else if (state.block_remaining != cfg.last_block_len)
                begin
                    code = smbr_pkg::RC_BADLAST;
                end
                else
                begin
                    code = smbr_pkg::RC_DONE;
                end
            end
            else if (b == cfg.status_opcode)
            begin
                code = state.awaiting_first ? smbr_pkg::RC_NOPKT : smbr_pkg::RC_STATMID;
            end
            else
            begin
                code = smbr_pkg::RC_BADOP;
            end
        end
        else if (state.block_remaining != '0)
        begin
            state_next.block_remaining = state.block_remaining - 1'b1;
            if ((state.block_kind == smbr_pkg::KIND_COPY) && (state.copied_count < limit))
            begin
                result.payload_byte     = b;
                result.payload_valid    = 1'b1;
                state_next.copied_count = state.copied_count + 1'b1;
                result.packet_len       = state.copied_count + 1'b1;
            end
        end

        // Any reported code ends the packet.
        if (code != smbr_pkg::RC_NONE)
        begin
            state_next.awaiting_first = 1'b1;
            state_next.copied_count   = '0;
        end

        result.result_code = code;
    end

endmodule

// ----- rtl/smbr_out_reg.sv -----
module smbr_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  smbr_pkg::result_t res_in,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output smbr_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    smbr_pkg::result_t res_reg;

    // Take a new request when empty or when the held result leaves this cycle.
    assign ready      = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
